// File: design/skhd_pkg.sv
// ----------------------------------------------------------------------------
// skhd_pkg
// Shared types and codes for the string-keyed hash dictionary.
// ----------------------------------------------------------------------------
package skhd_pkg;

  localparam int IdW      = 15;
  localparam int HashSeed = 5381;

  localparam logic [1:0] FUNC_LOOKUP    = 2'd0;
  localparam logic [1:0] FUNC_INSERT    = 2'd1;
  localparam int         FuncClearBit   = 1;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_INSERTED  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  typedef struct packed {
    logic [1:0]     func;
    logic [7:0]     key_byte;
    logic           last_byte;
    logic [IdW-1:0] entry_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]     status;
    logic [IdW-1:0] found_id;
  } out_item_t;

endpackage

// File: design/skhd_gather.sv
// ----------------------------------------------------------------------------
// skhd_gather
// Key byte buffer, length counter and running DJB2 hash.
// ----------------------------------------------------------------------------
module skhd_gather #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int KEY_BYTES     = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             byte_en,
  input  logic                             restart,
  input  logic [7:0]                       key_byte,
  input  logic                             last_byte,
  input  logic [$clog2(KEY_BYTES)-1:0]     kb_raddr,
  output logic [7:0]                       kb_rdata,
  output logic [$clog2(TABLE_ENTRIES)-1:0] hash_nxt,
  output logic [$clog2(KEY_BYTES)-1:0]     len_nxt,
  output logic                             ovf_nxt
);

  localparam int TblW = $clog2(TABLE_ENTRIES);
  localparam int KbW  = $clog2(KEY_BYTES);
  localparam int HW   = TblW + 9;
  localparam logic [TblW-1:0] Seed = TblW'(skhd_pkg::HashSeed % TABLE_ENTRIES);

  logic [7:0]      kb_mem [KEY_BYTES];
  logic [TblW-1:0] hash_r;
  logic [KbW-1:0]  len_r;
  logic            ovf_r;
  logic            can_take;
  logic [HW-1:0]   h_wide;

  assign can_take = len_r < KbW'(KEY_BYTES - 1);
  assign h_wide   = (HW'(hash_r) << 5) + HW'(hash_r) + HW'(key_byte);
  assign hash_nxt = can_take ? h_wide[TblW-1:0] : hash_r;
  assign len_nxt  = can_take ? len_r + KbW'(1) : len_r;
  assign ovf_nxt  = ovf_r | ~can_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= Seed;
      len_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (restart || (byte_en && last_byte)) begin
      hash_r <= Seed;
      len_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (byte_en) begin
      hash_r <= hash_nxt;
      len_r  <= len_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en && can_take) begin
      kb_mem[len_r] <= key_byte;
    end
    kb_rdata <= kb_mem[kb_raddr];
  end

endmodule

// File: design/skhd_probe.sv
// ----------------------------------------------------------------------------
// skhd_probe
// Slot memories and the sequencer that clears, inserts and looks up.
// ----------------------------------------------------------------------------
module skhd_probe #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int KEY_BYTES     = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start_op,
  input  logic                                 start_clr,
  input  logic                                 op_insert,
  input  logic [skhd_pkg::IdW-1:0]             id_in,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]     hash_in,
  input  logic [$clog2(KEY_BYTES)-1:0]         len_in,
  input  logic                                 ovf_in,
  output logic [$clog2(KEY_BYTES)-1:0]         kb_raddr,
  input  logic [7:0]                           kb_rdata,
  output logic                                 res_valid,
  output skhd_pkg::out_item_t                  res,
  input  logic                                 res_ready,
  output logic                                 idle
);

  localparam int TblW = $clog2(TABLE_ENTRIES);
  localparam int KbW  = $clog2(KEY_BYTES);
  localparam int IdW  = skhd_pkg::IdW;

  localparam logic [3:0] S_SWEEP   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_RD      = 4'd2;
  localparam logic [3:0] S_CHK     = 4'd3;
  localparam logic [3:0] S_CMP_RD  = 4'd4;
  localparam logic [3:0] S_CMP_CHK = 4'd5;
  localparam logic [3:0] S_CPY_RD  = 4'd6;
  localparam logic [3:0] S_CPY_WR  = 4'd7;
  localparam logic [3:0] S_RESP    = 4'd8;

  logic            occ_mem [TABLE_ENTRIES];
  logic [IdW-1:0]  id_mem  [TABLE_ENTRIES];
  logic [KbW-1:0]  len_mem [TABLE_ENTRIES];
  logic [7:0]      byte_mem[TABLE_ENTRIES * (2 ** KbW)];

  logic [3:0]      state_r, state_nxt;
  logic [TblW-1:0] slot_r, slot_nxt;
  logic [TblW-1:0] cnt_r, cnt_nxt;
  logic [KbW-1:0]  idx_r, idx_nxt;
  logic [KbW-1:0]  klen_r, klen_nxt;
  logic [IdW-1:0]  kid_r, kid_nxt;
  logic            ins_r, ins_nxt;
  logic            clr_resp_r, clr_resp_nxt;
  skhd_pkg::out_item_t res_r, res_nxt;

  logic            occ_rd;
  logic [IdW-1:0]  id_rd;
  logic [KbW-1:0]  len_rd;
  logic [7:0]      byte_rd;
  logic            occ_we, occ_wd, meta_we, byte_we;

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign res       = res_r;
  assign kb_raddr  = idx_r;

  always_comb begin
    state_nxt    = state_r;
    slot_nxt     = slot_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    klen_nxt     = klen_r;
    kid_nxt      = kid_r;
    ins_nxt      = ins_r;
    clr_resp_nxt = clr_resp_r;
    res_nxt      = res_r;
    occ_we       = 1'b0;
    occ_wd       = 1'b0;
    meta_we      = 1'b0;
    byte_we      = 1'b0;
    unique case (state_r)
      S_SWEEP: begin
        occ_we   = 1'b1;
        slot_nxt = slot_r + TblW'(1);
        if (slot_r == {TblW{1'b1}}) begin
          if (clr_resp_r) begin
            res_nxt   = '{status: skhd_pkg::ST_CLEARED, found_id: '0};
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (start_clr) begin
          slot_nxt     = '0;
          clr_resp_nxt = 1'b1;
          state_nxt    = S_SWEEP;
        end else if (start_op) begin
          slot_nxt = hash_in;
          cnt_nxt  = '0;
          klen_nxt = len_in;
          kid_nxt  = id_in;
          ins_nxt  = op_insert;
          if (ovf_in) begin
            res_nxt   = '{status: skhd_pkg::ST_TOO_LONG, found_id: '0};
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        idx_nxt = '0;
        if (ins_r && !occ_rd) begin
          occ_we  = 1'b1;
          occ_wd  = 1'b1;
          meta_we = 1'b1;
          res_nxt = '{status: skhd_pkg::ST_INSERTED, found_id: '0};
          state_nxt = (klen_r == '0) ? S_RESP : S_CPY_RD;
        end else if (!ins_r && !occ_rd) begin
          res_nxt   = '{status: skhd_pkg::ST_NOT_FOUND, found_id: '0};
          state_nxt = S_RESP;
        end else if (!ins_r && len_rd == klen_r) begin
          if (klen_r == '0) begin
            res_nxt   = '{status: skhd_pkg::ST_FOUND, found_id: id_rd};
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_CMP_RD;
          end
        end else if (cnt_r == {TblW{1'b1}}) begin
          res_nxt = '{status: ins_r ? skhd_pkg::ST_FULL : skhd_pkg::ST_NOT_FOUND,
                      found_id: '0};
          state_nxt = S_RESP;
        end else begin
          cnt_nxt   = cnt_r + TblW'(1);
          slot_nxt  = slot_r + TblW'(1);
          state_nxt = S_RD;
        end
      end
      S_CMP_RD: state_nxt = S_CMP_CHK;
      S_CMP_CHK: begin
        if (byte_rd != kb_rdata) begin
          // Mismatch: move on to the next slot, or give up after a full circle.
          if (cnt_r == {TblW{1'b1}}) begin
            res_nxt   = '{status: skhd_pkg::ST_NOT_FOUND, found_id: '0};
            state_nxt = S_RESP;
          end else begin
            cnt_nxt   = cnt_r + TblW'(1);
            slot_nxt  = slot_r + TblW'(1);
            state_nxt = S_RD;
          end
        end else if (idx_r + KbW'(1) == klen_r) begin
          res_nxt   = '{status: skhd_pkg::ST_FOUND, found_id: id_rd};
          state_nxt = S_RESP;
        end else begin
          idx_nxt   = idx_r + KbW'(1);
          state_nxt = S_CMP_RD;
        end
      end
      S_CPY_RD: state_nxt = S_CPY_WR;
      S_CPY_WR: begin
        byte_we = 1'b1;
        idx_nxt = idx_r + KbW'(1);
        state_nxt = (idx_r + KbW'(1) == klen_r) ? S_RESP : S_CPY_RD;
      end
      S_RESP: begin
        if (res_ready) begin
          clr_resp_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_SWEEP;
      slot_r     <= '0;
      clr_resp_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      slot_r     <= slot_nxt;
      clr_resp_r <= clr_resp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    klen_r <= klen_nxt;
    kid_r  <= kid_nxt;
    ins_r  <= ins_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[slot_r] <= occ_wd;
    end
    occ_rd <= occ_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      id_mem[slot_r]  <= kid_r;
      len_mem[slot_r] <= klen_r;
    end
    id_rd  <= id_mem[slot_r];
    len_rd <= len_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (byte_we) begin
      byte_mem[{slot_r, idx_r}] <= kb_rdata;
    end
    byte_rd <= byte_mem[{slot_r, idx_r}];
  end

endmodule

// File: design/string_key_hash_dictionary_top.sv
// ----------------------------------------------------------------------------
// string_key_hash_dictionary_top
// Byte-string dictionary with DJB2 hashing and linear probing.
// ----------------------------------------------------------------------------
// Key bytes are taken one per cycle while the probe sequencer is idle; a byte
// that is not the last gives no result. On the last byte of a lookup or
// insert the sequencer walks the table through single-port slot memories:
// each slot visited is read and then checked; on a lookup whose lengths
// match, or on an insert, each key byte is read and then compared or copied;
// last the result is handed over. A clear sweeps the occupied map one slot a
// cycle and gives a cleared result; after reset the same sweep runs with no
// result before the first byte is taken. TABLE_ENTRIES must be a power of two.
module string_key_hash_dictionary_top #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int KEY_BYTES     = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  skhd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output skhd_pkg::out_item_t out_data
);

  localparam int TblW = $clog2(TABLE_ENTRIES);
  localparam int KbW  = $clog2(KEY_BYTES);

  logic            in_xfer, is_clr, eng_idle;
  logic [KbW-1:0]  kb_raddr, len_nxt;
  logic [7:0]      kb_rdata;
  logic [TblW-1:0] hash_nxt;
  logic            ovf_nxt;
  logic            res_valid, res_ready;
  skhd_pkg::out_item_t res;
  logic            out_valid_r;
  skhd_pkg::out_item_t out_data_r;

  assign in_stall = ~eng_idle;
  assign in_xfer  = in_valid & eng_idle;
  assign is_clr   = in_data.func[skhd_pkg::FuncClearBit];

  skhd_gather #(.TABLE_ENTRIES(TABLE_ENTRIES), .KEY_BYTES(KEY_BYTES)) u_gather (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (in_xfer & ~is_clr),
    .restart   (in_xfer & is_clr),
    .key_byte  (in_data.key_byte),
    .last_byte (in_data.last_byte),
    .kb_raddr  (kb_raddr),
    .kb_rdata  (kb_rdata),
    .hash_nxt  (hash_nxt),
    .len_nxt   (len_nxt),
    .ovf_nxt   (ovf_nxt)
  );

  skhd_probe #(.TABLE_ENTRIES(TABLE_ENTRIES), .KEY_BYTES(KEY_BYTES)) u_probe (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_op  (in_xfer & ~is_clr & in_data.last_byte),
    .start_clr (in_xfer & is_clr),
    .op_insert (in_data.func == skhd_pkg::FUNC_INSERT),
    .id_in     (in_data.entry_id),
    .hash_in   (hash_nxt),
    .len_in    (len_nxt),
    .ovf_in    (ovf_nxt),
    .kb_raddr  (kb_raddr),
    .kb_rdata  (kb_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .idle      (eng_idle)
  );

  assign res_ready = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/skhd_checker.sv
// ----------------------------------------------------------------------------
// skhd_checker
// Port-level assertions for the dictionary, bound to the top level.
// ----------------------------------------------------------------------------
module skhd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input skhd_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input skhd_pkg::out_item_t out_data
);

  // A final byte or a clear starts the sequencer, so input is held off next.
  a_busy_after_op: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall &&
     (in_data.last_byte || in_data.func[skhd_pkg::FuncClearBit])) |=> in_stall)
    else $error("input not stalled after an operation started");

  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != skhd_pkg::ST_FOUND) |-> out_data.found_id == '0)
    else $error("found_id nonzero on a result that is not found");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == skhd_pkg::ST_FOUND ||
                   out_data.status == skhd_pkg::ST_NOT_FOUND ||
                   out_data.status == skhd_pkg::ST_INSERTED ||
                   out_data.status == skhd_pkg::ST_FULL ||
                   out_data.status == skhd_pkg::ST_TOO_LONG ||
                   out_data.status == skhd_pkg::ST_CLEARED))
    else $error("undefined status code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind string_key_hash_dictionary_top skhd_checker u_skhd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
